[sv/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned DefQueueDepth = 16;
  localparam int unsigned PriW = 8;
  localparam int unsigned TagW = 16;
  localparam int unsigned FillW = 5;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 32;

  localparam logic ReqPush = 1'b0;
  localparam logic ReqPop = 1'b1;

  typedef struct packed {
    logic [PriW-1:0] pri;
    logic [TagW-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic occ;
  } cell_ctrl_t;

endpackage

[sv/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t    new_entry,
  input  spq_pkg::entry_t    prev_entry,
  input  logic               prev_keep,
  input  spq_pkg::entry_t    next_entry,
  output spq_pkg::entry_t    entry,
  output logic               keep
);
  import spq_pkg::*;

  entry_t entry_next;

  // entry stays in place on a push when it ranks at or above the new one
  assign keep = ctrl.occ && (entry.pri >= new_entry.pri);

  always_comb begin
    entry_next = entry;
    if (ctrl.push) begin
      if (!keep) begin
        entry_next = prev_keep ? new_entry : prev_entry;
      end
    end else if (ctrl.pop) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[sv/stable_priority_queue_unit.sv]
`timescale 1ns / 1ps
// the result is registered and shown on m_axis in the cycle after the input transaction
// throughput: one transaction per cycle while results are read out, the whole cell row updates together
// input is taken only while the result register is empty or being read out
// reset: synchronous rst empties the queue and drops any pending result
// slot contents are not cleared, occupancy follows the fill count

module stable_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::DefQueueDepth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_priority, entry_tag
  input  logic [spq_pkg::InDataW-1:0]   s_axis_tdata,
  // req_type
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // push_accepted, pop_valid, pop_priority, pop_tag, fill_level, zero pad
  output logic [spq_pkg::OutDataW-1:0]  m_axis_tdata
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            out_valid;
  logic            push_accepted;
  logic            pop_valid;
  entry_t          pop_entry;
  logic [FillW-1:0] fill_level;

  logic            take;
  logic            do_push;
  logic            do_pop;
  entry_t          new_entry;
  entry_t          cells [QUEUE_DEPTH];
  logic            keeps [QUEUE_DEPTH];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;
  assign new_entry.pri = s_axis_tdata[PriW-1:0];
  assign new_entry.tag = s_axis_tdata[PriW+TagW-1:PriW];
  assign do_push = take && (s_axis_tuser == ReqPush) && (count != CntW'(QUEUE_DEPTH));
  assign do_pop = take && (s_axis_tuser == ReqPop) && (count != '0);

  always_comb begin
    count_next = count;
    if (do_push) begin
      count_next = count + 1'b1;
    end else if (do_pop) begin
      count_next = count - 1'b1;
    end
  end

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctrl_t ctrl;
      entry_t     prev_e;
      entry_t     next_e;
      logic       prev_k;

      assign ctrl.push = do_push;
      assign ctrl.pop = do_pop;
      assign ctrl.occ = count > CntW'(i);

      if (i == 0) begin : g_head
        assign prev_e = new_entry;
        assign prev_k = 1'b1;
      end else begin : g_body
        assign prev_e = cells[i-1];
        assign prev_k = keeps[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign next_e = '0;
      end else begin : g_inner
        assign next_e = cells[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_entry  (new_entry),
        .prev_entry (prev_e),
        .prev_keep  (prev_k),
        .next_entry (next_e),
        .entry      (cells[i]),
        .keep       (keeps[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      push_accepted <= do_push;
      pop_valid <= do_pop;
      pop_entry <= do_pop ? cells[0] : '0;
      fill_level <= FillW'(count_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {
    {(OutDataW - FillW - TagW - PriW - 2){1'b0}},
    fill_level, pop_entry.tag, pop_entry.pri, pop_valid, push_accepted
  };

endmodule

[sim/tb_stable_priority_queue_unit.sv]
`timescale 1ns / 1ps

module tb_stable_priority_queue_unit;
  import spq_pkg::*;

  localparam int unsigned QDEPTH = DefQueueDepth;
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic drain;
    logic kind;
    logic [PriW-1:0] pri;
    logic [TagW-1:0] tag;
  } req_t;

  typedef struct packed {
    logic accepted;
    logic valid;
    logic [PriW-1:0] pri;
    logic [TagW-1:0] tag;
    logic [FillW-1:0] fill;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  stable_priority_queue_unit #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t pending_reqs[$];
  result_t expected_results[$];
  req_t in_flight;
  int sent_count = 0;
  int fail_count = 0;
  int hold_left = 0;
  int holds_done = 0;

  // shadow copy of the sorted queue
  logic [PriW-1:0] q_pri[QDEPTH];
  logic [TagW-1:0] q_tag[QDEPTH];
  int q_count = 0;
  int pushes_stored = 0;
  int pushes_refused = 0;
  int pops_served = 0;
  int pops_empty = 0;

  function automatic int send_idle_pct(input int n);
    if (n < 480) return 38;
    if (n < 960) return 51;
    return 0;
  endfunction

  function automatic int recv_idle_pct(input int n);
    if (n < 480) return 51;
    if (n < 960) return 38;
    return 0;
  endfunction

  task automatic apply_request(input req_t r);
    result_t res;
    int pos;
    res = '0;
    if (r.kind == ReqPush) begin
      if (q_count < QDEPTH) begin
        pos = q_count;
        for (int i = 0; i < q_count; i++) begin
          if (pos == q_count && q_pri[i] < r.pri) pos = i;
        end
        for (int i = q_count; i > pos; i--) begin
          q_pri[i] = q_pri[i-1];
          q_tag[i] = q_tag[i-1];
        end
        q_pri[pos] = r.pri;
        q_tag[pos] = r.tag;
        q_count++;
        res.accepted = 1'b1;
        pushes_stored++;
      end else begin
        pushes_refused++;
      end
    end else begin
      if (q_count > 0) begin
        res.valid = 1'b1;
        res.pri = q_pri[0];
        res.tag = q_tag[0];
        for (int i = 1; i < q_count; i++) begin
          q_pri[i-1] = q_pri[i];
          q_tag[i-1] = q_tag[i];
        end
        q_count--;
        pops_served++;
      end else begin
        pops_empty++;
      end
    end
    res.fill = q_count[FillW-1:0];
    expected_results.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [TagW-1:0] exp_v,
                             input logic [TagW-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  task automatic add_push(input logic [PriW-1:0] pri, input logic [TagW-1:0] tag);
    pending_reqs.push_back('{drain: 1'b0, kind: ReqPush, pri: pri, tag: tag});
  endtask

  task automatic add_pop(input logic [PriW-1:0] pri, input logic [TagW-1:0] tag);
    pending_reqs.push_back('{drain: 1'b0, kind: ReqPop, pri: pri, tag: tag});
  endtask

  task automatic add_drain();
    pending_reqs.push_back('{drain: 1'b1, kind: ReqPush, pri: '0, tag: '0});
  endtask

  // request driver
  always @(posedge clk) begin
    req_t nxt;
    logic nv;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      nv = s_axis_tvalid && !s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(in_flight);
        sent_count <= sent_count + 1;
      end
      if (!nv) begin
        // pause until every outstanding result is back
        if (pending_reqs.size() > 0 && pending_reqs[0].drain &&
            expected_results.size() == 0) begin
          void'(pending_reqs.pop_front());
        end
        if (pending_reqs.size() > 0 && !pending_reqs[0].drain &&
            $urandom_range(99) >= send_idle_pct(sent_count)) begin
          nxt = pending_reqs.pop_front();
          in_flight <= nxt;
          s_axis_tdata <= {nxt.tag, nxt.pri};
          s_axis_tuser <= nxt.kind;
          nv = 1'b1;
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // result backpressure, with long holds so the unit fills and stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && sent_count >= ((holds_done == 0) ? 250 : 1100)) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct(sent_count));
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: tdata %0h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("push_accepted", TagW'(exp_r.accepted), TagW'(m_axis_tdata[0]));
        check_field("pop_valid", TagW'(exp_r.valid), TagW'(m_axis_tdata[1]));
        check_field("pop_priority", TagW'(exp_r.pri), TagW'(m_axis_tdata[9:2]));
        check_field("pop_tag", exp_r.tag, m_axis_tdata[25:10]);
        check_field("fill_level", TagW'(exp_r.fill), TagW'(m_axis_tdata[30:26]));
      end
    end
  end

  initial begin
    int n_random;
    int blocks;
    int len;
    int push_pct;
    logic narrow;

    // empty pop, extremes, ties kept in arrival order, ignored pop fields
    add_pop('0, '0);
    add_push(8'hff, 16'hffff);
    add_push(8'h00, 16'h0000);
    add_push(8'hff, 16'h0001);
    add_push(8'h80, 16'h1234);
    add_push(8'h80, 16'h5678);
    add_push(8'h00, 16'hffff);
    add_pop(8'hff, 16'hffff);
    repeat (6) add_pop(8'h00, 16'h0000);
    add_drain();

    n_random = 0;
    blocks = 0;
    while (n_random < RANDOM_ITEMS) begin
      len = $urandom_range(60, 20);
      case ($urandom_range(2))
        0: push_pct = 20;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      narrow = $urandom_range(1);
      if (blocks % 6 == 5) add_drain();
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(99) < push_pct) begin
          if (narrow) add_push(8'($urandom_range(3)), 16'($urandom));
          else add_push(8'($urandom), 16'($urandom));
        end else begin
          add_pop(8'($urandom), 16'($urandom));
        end
      end
      n_random += len;
      blocks++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests: %0d pushes stored, %0d refused on full queue",
             sent_count, pushes_stored, pushes_refused);
    $display("%0d pops served, %0d pops on empty queue, %0d long output holds",
             pops_served, pops_empty, holds_done);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for results");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
